// File: sv/clcd_pkg.sv
// ----------------------------------------------------------------------------
// Character LCD nibble sequencer package
// Shared types, request codes, timing constants and the step generator.
// ----------------------------------------------------------------------------
`default_nettype none

package clcd_pkg;

  typedef enum logic [2:0] {
    REQ_INIT      = 3'd0,
    REQ_COMMAND   = 3'd1,
    REQ_CHAR      = 3'd2,
    REQ_CURSOR    = 3'd3,
    REQ_CLEAR     = 3'd4,
    REQ_STR_START = 3'd5,
    REQ_STR_CHAR  = 3'd6,
    REQ_STR_END   = 3'd7
  } req_type_t;

  localparam int unsigned JobDepth  = 4;
  localparam int unsigned JobPtrW   = $clog2(JobDepth);
  localparam int unsigned InitSteps = 19;
  localparam int unsigned StepW     = $clog2(InitSteps);

  localparam logic [StepW-1:0] InitLastStep  = StepW'(InitSteps - 1);
  localparam logic [StepW-1:0] InitByteFirst = StepW'(5);

  localparam logic [16:0] WaitPowerUp = 17'd100000;
  localparam logic [16:0] WaitWake1   = 17'd10000;
  localparam logic [16:0] WaitWake2   = 17'd125;
  localparam logic [16:0] WaitByte    = 17'd1000;
  localparam logic [16:0] WaitClear   = 17'd11000;

  localparam logic [7:0] CmdClear  = 8'h01;
  localparam logic [7:0] CmdLine1  = 8'h80;
  localparam logic [7:0] CmdLine2  = 8'hC0;
  localparam logic [3:0] NibWake   = 4'h3;
  localparam logic [3:0] NibFour   = 4'h2;
  localparam logic [4:0] WrapCol   = 5'd15;
  localparam logic [4:0] ColMax    = 5'd31;

  // One queued job: either the power-up sequence or one byte, optionally
  // followed by a move to the second line.
  typedef struct packed {
    logic       is_init;
    logic       rs;
    logic [7:0] data;
    logic       clear_wait;
    logic       wrap;
  } job_t;

  typedef struct packed {
    logic        rs;
    logic [3:0]  nibble;
    logic        pulse;
    logic [16:0] wait_us;
    logic        last;
  } step_t;

  function automatic logic [7:0] init_byte(input logic [2:0] idx);
    logic [7:0] b;
    case (idx)
      3'd0:    b = 8'h28;
      3'd1:    b = 8'h08;
      3'd2:    b = 8'h01;
      3'd3:    b = 8'h06;
      3'd4:    b = 8'h28;
      3'd5:    b = 8'h0E;
      3'd6:    b = 8'h06;
      default: b = 8'h00;
    endcase
    return b;
  endfunction

  function automatic step_t step_fields(input job_t job, input logic [StepW-1:0] step);
    step_t            s;
    logic [StepW-1:0] k;
    logic [7:0]       b;
    s = '0;
    k = step - InitByteFirst;
    b = 8'h00;
    if (job.is_init) begin
      case (step)
        5'd0: begin
          s.wait_us = WaitPowerUp;
        end
        5'd1: begin
          s.pulse = 1'b1; s.nibble = NibWake; s.wait_us = WaitWake1;
        end
        5'd2: begin
          s.pulse = 1'b1; s.nibble = NibWake; s.wait_us = WaitWake2;
        end
        5'd3: begin
          s.pulse = 1'b1; s.nibble = NibWake; s.wait_us = WaitByte;
        end
        5'd4: begin
          s.pulse = 1'b1; s.nibble = NibFour; s.wait_us = WaitByte;
        end
        default: begin
          b         = init_byte(k[3:1]);
          s.pulse   = 1'b1;
          s.nibble  = k[0] ? b[3:0] : b[7:4];
          s.wait_us = k[0] ? WaitByte : 17'd0;
        end
      endcase
      s.last = (step == InitLastStep);
    end else begin
      // Steps two and three carry the second-line command after a wrap.
      b         = step[1] ? CmdLine2 : job.data;
      s.rs      = step[1] ? 1'b0 : job.rs;
      s.pulse   = 1'b1;
      s.nibble  = step[0] ? b[3:0] : b[7:4];
      s.wait_us = !step[0] ? 17'd0 :
                  (job.clear_wait && !step[1]) ? WaitClear : WaitByte;
      s.last    = step[0] && (step[1] || !job.wrap);
    end
    return s;
  endfunction

endpackage

`default_nettype wire

// File: sv/clcd_front.sv
// ----------------------------------------------------------------------------
// Request classifier
// Turns each request into a job descriptor and keeps the string column.
// ----------------------------------------------------------------------------
`default_nettype none

module clcd_front (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          req_valid,
  input  wire logic [2:0]    req_type,
  input  wire logic [7:0]    byte_value,
  input  wire logic [5:0]    cursor_col,
  input  wire logic          cursor_row,
  output clcd_pkg::job_t     job,
  output logic               job_push
);
  import clcd_pkg::*;

  logic [4:0] col_r, col_nxt;
  req_type_t  rtype;

  assign rtype    = req_type_t'(req_type);
  assign job_push = req_valid;

  always_comb begin
    job     = '0;
    col_nxt = col_r;
    case (rtype)
      REQ_INIT: begin
        job.is_init = 1'b1;
      end
      REQ_COMMAND: begin
        job.data = byte_value;
      end
      REQ_CHAR: begin
        job.rs   = 1'b1;
        job.data = byte_value;
      end
      REQ_CURSOR: begin
        job.data = (cursor_row ? CmdLine2 : CmdLine1) + {2'b00, cursor_col};
      end
      REQ_CLEAR: begin
        job.data       = CmdClear;
        job.clear_wait = 1'b1;
      end
      REQ_STR_START: begin
        job.data       = CmdClear;
        job.clear_wait = 1'b1;
        col_nxt        = '0;
      end
      REQ_STR_CHAR: begin
        job.rs   = 1'b1;
        job.data = byte_value;
        job.wrap = (col_r == WrapCol);
        if (col_r != ColMax) begin
          col_nxt = col_r + 5'd1;
        end
      end
      REQ_STR_END: begin
        job.data = CmdLine1;
      end
      default: begin
        job = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
    end else if (req_valid) begin
      col_r <= col_nxt;
    end
  end

endmodule

`default_nettype wire

// File: sv/clcd_job_fifo.sv
// ----------------------------------------------------------------------------
// Job queue
// Short queue between the classifier and the step sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

module clcd_job_fifo (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           push,
  input  wire clcd_pkg::job_t push_job,
  output logic                full,
  input  wire logic           pop,
  output clcd_pkg::job_t      head,
  output logic                head_valid
);
  import clcd_pkg::*;

  job_t               mem [JobDepth];
  logic [JobPtrW-1:0] wr_r, wr_nxt, rd_r, rd_nxt;
  logic [JobPtrW:0]   cnt_r, cnt_nxt;
  logic               do_push, do_pop;

  assign full       = (cnt_r == (JobPtrW+1)'(JobDepth));
  assign head_valid = (cnt_r != '0);
  assign head       = mem[rd_r];
  assign do_push    = push && !full;
  assign do_pop     = pop && head_valid;

  always_comb begin
    wr_nxt  = do_push ? wr_r + 1'b1 : wr_r;
    rd_nxt  = do_pop ? rd_r + 1'b1 : rd_r;
    cnt_nxt = cnt_r + (JobPtrW+1)'(do_push) - (JobPtrW+1)'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_r] <= push_job;
    end
  end

endmodule

`default_nettype wire

// File: sv/clcd_back.sv
// ----------------------------------------------------------------------------
// Step sequencer
// Expands the queue head into nibble steps, one a cycle unless output stalls.
// ----------------------------------------------------------------------------
`default_nettype none

module clcd_back (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire clcd_pkg::job_t head,
  input  wire logic           head_valid,
  output logic                head_pop,
  output clcd_pkg::step_t     step_out,
  output logic                step_valid,
  input  wire logic           step_pop
);
  import clcd_pkg::*;

  logic [StepW-1:0] step_r, step_nxt;
  logic             valid_r, valid_nxt;
  step_t            out_r;
  step_t            cur;
  logic             advance;

  assign cur        = step_fields(head, step_r);
  // The output register moves on when it is empty or its step is taken.
  assign advance    = !valid_r || step_pop;
  assign head_pop   = advance && head_valid && cur.last;
  assign step_out   = out_r;
  assign step_valid = valid_r;

  always_comb begin
    step_nxt  = step_r;
    valid_nxt = valid_r;
    if (advance) begin
      valid_nxt = head_valid;
      if (head_valid) begin
        step_nxt = cur.last ? '0 : step_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r  <= '0;
      valid_r <= 1'b0;
    end else begin
      step_r  <= step_nxt;
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && head_valid) begin
      out_r <= cur;
    end
  end

`ifndef SYNTHESIS
  a_step_range: assert property (@(posedge clk) disable iff (!rst_n)
    step_r <= InitLastStep)
    else $error("step index beyond the power-up sequence");

  a_job_held: assert property (@(posedge clk) disable iff (!rst_n)
    step_r != '0 |-> head_valid)
    else $error("job left the queue part-way through its run");

  a_wrap_only: assert property (@(posedge clk) disable iff (!rst_n)
    (step_r >= StepW'(2) && !head.is_init) |-> head.wrap)
    else $error("byte job ran past two steps without a line wrap");

  a_last_pops: assert property (@(posedge clk) disable iff (!rst_n)
    head_pop |=> step_r == '0)
    else $error("step index not cleared after the final step");
`endif

endmodule

`default_nettype wire

// File: sv/char_lcd_nibble_sequencer.sv
// ----------------------------------------------------------------------------
// Character LCD nibble sequencer
// Turns display requests into timed nibble steps for a 4-bit LCD bus.
// ----------------------------------------------------------------------------
// Each request is classified on entry and queued as a job in a four-entry
// queue; the step sequencer then emits one nibble step per clock cycle from
// the job at its head into a registered output, unless a step waits
// unpopped. A request expands into 19 steps for power-up initialization,
// 4 for a string character that wraps to line two, and 2 for every other
// request. The sequencer's one-step-per-cycle expansion sets the sustained
// rate; requests are accepted every cycle while the job queue has room,
// also while a step waits on the result side. The step carries the wait
// the caller must time out before taking the next step.
`default_nettype none

module char_lcd_nibble_sequencer (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_push,
  output logic             in_full,
  input  wire logic [2:0]  in_req_type,
  input  wire logic [7:0]  in_byte_value,
  input  wire logic [5:0]  in_cursor_col,
  input  wire logic        in_cursor_row,
  output logic             out_empty,
  input  wire logic        out_pop,
  output logic             out_reg_select,
  output logic [3:0]       out_bus_nibble,
  output logic             out_pulse_enable,
  output logic [16:0]      out_wait_after_us,
  output logic             out_last
);
  import clcd_pkg::*;

  job_t  new_job, head_job;
  logic  new_push, head_valid, head_pop, step_valid;
  step_t step;

  clcd_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .req_valid  (in_push && !in_full),
    .req_type   (in_req_type),
    .byte_value (in_byte_value),
    .cursor_col (in_cursor_col),
    .cursor_row (in_cursor_row),
    .job        (new_job),
    .job_push   (new_push)
  );

  clcd_job_fifo u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (new_push),
    .push_job   (new_job),
    .full       (in_full),
    .pop        (head_pop),
    .head       (head_job),
    .head_valid (head_valid)
  );

  clcd_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head       (head_job),
    .head_valid (head_valid),
    .head_pop   (head_pop),
    .step_out   (step),
    .step_valid (step_valid),
    .step_pop   (out_pop)
  );

  assign out_empty         = !step_valid;
  assign out_reg_select    = step.rs;
  assign out_bus_nibble    = step.nibble;
  assign out_pulse_enable  = step.pulse;
  assign out_wait_after_us = step.wait_us;
  assign out_last          = step.last;

endmodule

`default_nettype wire
